[design/hrrs_pkg.sv]
package hrrs_pkg;

   // Opcodes of a request
   localparam logic OP_SUBMIT   = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_SUBMITTED  = 2'd0;
   localparam logic [1:0] STATUS_DISPATCHED = 2'd1;
   localparam logic [1:0] STATUS_FULL       = 2'd2;
   localparam logic [1:0] STATUS_EMPTY      = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [31:0] now;
      logic [7:0]  job_tag;
      logic [15:0] service_estimate;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  chosen_tag;
      logic [31:0] chosen_wait;
      logic [15:0] chosen_service;
   } rsp_type;

   // One table entry as held in the slot memory
   typedef struct packed {
      logic [31:0] arrival;
      logic [15:0] service;
      logic [7:0]  tag;
   } slot_entry_type;

   // Best candidate found so far during a dispatch scan
   typedef struct packed {
      logic        found;
      logic [7:0]  tag;
      logic [31:0] elapsed;
      logic [15:0] service;
   } best_type;

   // Steps of the ratio datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic mul;
      logic cmp;
   } ratio_ctrl_type;

   // Completion events towards the response register
   typedef struct packed {
      logic submit_ok;
      logic submit_full;
      logic dispatch;
   } done_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB_SCAN,
      ST_LOAD,
      ST_MUL,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

[design/hrrs_slot_mem.sv]
module hrrs_slot_mem #(
   parameter int SLOTS = 16,
   parameter int IDX_W = 4
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_addr,
   input  hrrs_pkg::slot_entry_type wr_data,
   input  logic [IDX_W-1:0]        rd_addr,
   output hrrs_pkg::slot_entry_type rd_data
);
   import hrrs_pkg::*;

   slot_entry_type mem [SLOTS];
   slot_entry_type rd_data_ff;

   // Single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hrrs_ratio_unit.sv]
module hrrs_ratio_unit #(
   parameter int IDX_W = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hrrs_pkg::ratio_ctrl_type ctrl,
   input  logic [31:0]              now,
   input  hrrs_pkg::slot_entry_type entry,
   input  logic [IDX_W-1:0]         cur_idx,
   output hrrs_pkg::best_type       best,
   output logic [IDX_W-1:0]         best_idx
);
   import hrrs_pkg::*;

   logic [31:0]      cand_wait_ff;
   logic [15:0]      cand_svc_ff;
   logic [47:0]      prod_new_ff;
   logic [47:0]      prod_best_ff;
   logic             found_ff;
   logic [31:0]      best_wait_ff;
   logic [15:0]      best_svc_ff;
   logic [7:0]       best_tag_ff;
   logic [15:0]      best_raw_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [31:0]      wait_in;
   logic [15:0]      svc_in;
   logic             take;

   // Wait saturates at zero, a zero estimate counts as one
   assign wait_in = (now >= entry.arrival) ? (now - entry.arrival) : 32'd0;
   assign svc_in  = (entry.service == 16'd0) ? 16'd1 : entry.service;

   // Candidate wins on a strictly larger ratio, so ties keep the lower slot
   assign take = !found_ff || (prod_new_ff > prod_best_ff);

   // Candidate stage
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cand_wait_ff <= wait_in;
         cand_svc_ff  <= svc_in;
      end
   end

   // Cross products: cand_wait * best_svc against best_wait * cand_svc
   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_new_ff  <= 48'(cand_wait_ff) * 48'(best_svc_ff);
         prod_best_ff <= 48'(best_wait_ff) * 48'(cand_svc_ff);
      end
   end

   // Best-so-far flag
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (ctrl.cmp) begin
         found_ff <= 1'b1;
      end
   end

   // Best-so-far payload; the entry is still on the memory output here
   always_ff @(posedge clock) begin
      if (ctrl.cmp && take) begin
         best_wait_ff <= cand_wait_ff;
         best_svc_ff  <= cand_svc_ff;
         best_tag_ff  <= entry.tag;
         best_raw_ff  <= entry.service;
         best_idx_ff  <= cur_idx;
      end
   end

   assign best.found   = found_ff;
   assign best.tag     = best_tag_ff;
   assign best.elapsed = best_wait_ff;
   assign best.service = best_raw_ff;
   assign best_idx     = best_idx_ff;

endmodule

[design/hrrs_ctrl.sv]
module hrrs_ctrl #(
   parameter int SLOTS = 16,
   parameter int IDX_W = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     opcode,
   input  logic                     best_found,
   input  logic [IDX_W-1:0]         best_idx,
   output logic                     busy,
   output logic                     mem_wr,
   output logic [IDX_W-1:0]         idx,
   output logic [IDX_W-1:0]         idx_next,
   output hrrs_pkg::ratio_ctrl_type ratio_ctrl,
   output hrrs_pkg::done_type       done
);
   import hrrs_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   state_type        state_ff;
   state_type        state_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [SLOTS-1:0] valid_ff;
   logic             set_valid;
   logic             clr_valid;
   logic             cur_valid;
   logic             last;

   assign cur_valid = valid_ff[idx_ff];
   assign last      = (idx_ff == LAST_IDX);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (opcode == OP_DISPATCH) ? ST_LOAD : ST_SUB_SCAN;
            end
         end
         ST_SUB_SCAN: begin
            if (!cur_valid || last) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            if (cur_valid) begin
               state_in = ST_MUL;
            end else if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL:  state_in = ST_CMP;
         ST_CMP:  state_in = last ? ST_DONE : ST_LOAD;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and slot index
   always_comb begin
      busy       = 1'b1;
      mem_wr     = 1'b0;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
      idx_in     = idx_ff;
      ratio_ctrl = '0;
      done       = '0;
      case (state_ff)
         ST_IDLE: begin
            busy             = 1'b0;
            idx_in           = '0;
            ratio_ctrl.clear = start && (opcode == OP_DISPATCH);
         end
         ST_SUB_SCAN: begin
            if (!cur_valid) begin
               mem_wr         = 1'b1;
               set_valid      = 1'b1;
               done.submit_ok = 1'b1;
               idx_in         = '0;
            end else if (last) begin
               done.submit_full = 1'b1;
               idx_in           = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            if (cur_valid) begin
               ratio_ctrl.load = 1'b1;
            end else if (last) begin
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_MUL: begin
            ratio_ctrl.mul = 1'b1;
         end
         ST_CMP: begin
            ratio_ctrl.cmp = 1'b1;
            idx_in         = last ? '0 : (idx_ff + 1'b1);
         end
         ST_DONE: begin
            done.dispatch = 1'b1;
            clr_valid     = best_found;
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Occupancy bits, one per slot
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (set_valid) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (clr_valid) begin
            valid_ff[best_idx] <= 1'b0;
         end
      end
   end

   assign idx      = idx_ff;
   assign idx_next = idx_in;

endmodule

[design/highest_response_ratio_selector_core.sv]
// A submit scans from slot 0 and writes the job to the lowest free slot, or reports
// a full table when every slot is taken; the scan tests one occupancy bit per cycle.
// A dispatch reads, cross-multiplies and compares each pending slot, skips each empty
// slot and then finishes; the registered result follows the finishing step.
// One request at a time; busy drops in the result cycle and the receiver cannot stall.
// Reset clears occupancy bits, sequencer, best flag and strobe, but not the slot memory.
module highest_response_ratio_selector_core #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hrrs_pkg::req_type req_data,
   output logic              rsp_strobe,
   output hrrs_pkg::rsp_type rsp_data
);
   import hrrs_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   req_type          req_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_strobe_ff;
   logic             accept;
   logic             mem_wr;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] idx_next;
   ratio_ctrl_type   ratio_ctrl;
   done_type         done;
   best_type         best;
   logic [IDX_W-1:0] best_idx;
   slot_entry_type   wr_entry;
   slot_entry_type   rd_entry;

   assign accept = start && !busy;

   // Hold the request for the length of the operation
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   assign wr_entry.arrival = req_ff.now;
   assign wr_entry.service = req_ff.service_estimate;
   assign wr_entry.tag     = req_ff.job_tag;

   hrrs_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .opcode     (req_data.opcode),
      .best_found (best.found),
      .best_idx   (best_idx),
      .busy       (busy),
      .mem_wr     (mem_wr),
      .idx        (idx),
      .idx_next   (idx_next),
      .ratio_ctrl (ratio_ctrl),
      .done       (done)
   );

   // Read address follows the next slot index, so the output shows the current slot
   hrrs_slot_mem #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (idx),
      .wr_data (wr_entry),
      .rd_addr (idx_next),
      .rd_data (rd_entry)
   );

   hrrs_ratio_unit #(
      .IDX_W (IDX_W)
   ) u_ratio (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ratio_ctrl),
      .now      (req_ff.now),
      .entry    (rd_entry),
      .cur_idx  (idx),
      .best     (best),
      .best_idx (best_idx)
   );

   // Result formatting
   always_comb begin
      rsp_in = '0;
      if (done.submit_ok) begin
         rsp_in.status = STATUS_SUBMITTED;
      end else if (done.submit_full) begin
         rsp_in.status = STATUS_FULL;
      end else if (done.dispatch && best.found) begin
         rsp_in.status         = STATUS_DISPATCHED;
         rsp_in.chosen_tag     = best.tag;
         rsp_in.chosen_wait    = best.elapsed;
         rsp_in.chosen_service = best.service;
      end else begin
         rsp_in.status = STATUS_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done.submit_ok || done.submit_full || done.dispatch;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks

   // The result only appears once the sequencer is back at rest
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // An accepted request always occupies the block in the next cycle
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("accepted request did not start");

   // Only a dispatch result carries job fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != STATUS_DISPATCHED)) |->
      ((rsp_data.chosen_tag == 8'd0) && (rsp_data.chosen_wait == 32'd0) &&
       (rsp_data.chosen_service == 16'd0)))
      else $error("non-dispatch result with job fields");

endmodule

[sim/hrrs_pick_checker.sv]
module hrrs_pick_checker #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  hrrs_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  hrrs_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import hrrs_pkg::*;

   // Shadow of the job table
   logic          job_live    [SLOTS];
   logic [31:0]   job_arrival [SLOTS];
   logic [15:0]   job_svc     [SLOTS];
   logic [7:0]    job_tag     [SLOTS];

   // Outcomes of accepted requests, oldest first
   rsp_type       awaited_outcomes[$];
   rsp_type       oldest_outcome;

   // Work out the outcome of one request and update the shadow table
   function automatic rsp_type decide_outcome(req_type r);
      rsp_type     o;
      int          pick;
      logic [63:0] wait_now;
      logic [63:0] svc_now;
      logic [63:0] best_wait;
      logic [63:0] best_svc;
      o = '0;
      pick = -1;
      best_wait = '0;
      best_svc = 64'd1;
      if (r.opcode == OP_SUBMIT) begin
         // lowest free slot takes the job
         for (int s = 0; s < SLOTS; s++)
            if (pick < 0 && !job_live[s]) pick = s;
         if (pick < 0) begin
            o.status = STATUS_FULL;
         end else begin
            job_live[pick]    = 1'b1;
            job_arrival[pick] = r.now;
            job_svc[pick]     = r.service_estimate;
            job_tag[pick]     = r.job_tag;
            o.status = STATUS_SUBMITTED;
         end
      end else begin
         // largest wait/service by cross-multiplication, strict compare keeps lowest slot
         for (int s = 0; s < SLOTS; s++) begin
            if (job_live[s]) begin
               wait_now = (r.now >= job_arrival[s]) ? 64'(r.now - job_arrival[s]) : 64'd0;
               svc_now  = (job_svc[s] != 16'd0) ? 64'(job_svc[s]) : 64'd1;
               if (pick < 0 || wait_now * best_svc > best_wait * svc_now) begin
                  pick = s;
                  best_wait = wait_now;
                  best_svc = svc_now;
               end
            end
         end
         if (pick < 0) begin
            o.status = STATUS_EMPTY;
         end else begin
            job_live[pick] = 1'b0;
            o.status         = STATUS_DISPATCHED;
            o.chosen_tag     = job_tag[pick];
            o.chosen_wait    = best_wait[31:0];
            o.chosen_service = job_svc[pick];
         end
      end
      return o;
   endfunction

   // Count a failure, print the first ten
   function automatic void flag_result(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected st=%0d tag=%h wait=%h svc=%h, ",
                  $realtime, what, want.status, want.chosen_tag, want.chosen_wait,
                  want.chosen_service, "got st=%0d tag=%h wait=%h svc=%h",
                  got.status, got.chosen_tag, got.chosen_wait, got.chosen_service);
   endfunction

   // Results are matched before a request accepted on the same edge is queued
   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) job_live[s] = 1'b0;
         awaited_outcomes.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_outcomes.size() == 0) begin
               flag_result("result with no request outstanding", '0, rsp_data);
            end else begin
               oldest_outcome = awaited_outcomes.pop_front();
               if (rsp_data.status !== oldest_outcome.status ||
                   rsp_data.chosen_tag !== oldest_outcome.chosen_tag ||
                   rsp_data.chosen_wait !== oldest_outcome.chosen_wait ||
                   rsp_data.chosen_service !== oldest_outcome.chosen_service)
                  flag_result("result mismatch", oldest_outcome, rsp_data);
            end
         end
         if (start && !busy)
            awaited_outcomes.push_back(decide_outcome(req_data));
      end
      pending_count = awaited_outcomes.size();
   end

endmodule

[sim/tb_highest_response_ratio_selector_core.sv]
module tb_highest_response_ratio_selector_core;
   timeunit 1ns;
   timeprecision 1ps;

   import hrrs_pkg::*;

   localparam int SLOTS = 16;
   localparam int RANDOM_TARGET = 950;
   localparam int QUIET_FROM = 850;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   int          sent_count;
   logic [31:0] sched_time;

   highest_response_ratio_selector_core #(
      .SLOTS(SLOTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   hrrs_pick_checker #(
      .SLOTS(SLOTS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Present one request at the falling edge and hold it until accepted
   task automatic issue(logic op, logic [31:0] at, logic [7:0] tag, logic [15:0] svc);
      req_type r;
      r.opcode = op;
      r.now = at;
      r.job_tag = tag;
      r.service_estimate = svc;
      if (sent_count < QUIET_FROM && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
      @(negedge clock);
      start = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   // Hold off until every outstanding request has answered
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   // Small services often for ratio ties, zero and all-ones sometimes, else any value
   function automatic logic [15:0] pick_service();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 16'd0;
      if (roll < 8) return 16'($urandom_range(1, 8));
      if (roll == 8) return 16'hffff;
      return 16'($urandom_range(1, 65535));
   endfunction

   // Time mostly moves forward in small steps, with the odd jump or step back
   function automatic void advance_time();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) sched_time = $urandom;
      else if (roll == 1) sched_time = sched_time - $urandom_range(1, 100);
      else sched_time = sched_time + $urandom_range(0, 40);
   endfunction

   initial begin
      int mode;
      int burst;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      sent_count = 0;
      sched_time = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, field extremes, zero service, late arrival
      issue(OP_DISPATCH, 32'd5, 8'h00, 16'h0000);
      issue(OP_SUBMIT, 32'h0000_0000, 8'h00, 16'h0001);
      issue(OP_SUBMIT, 32'hffff_ffff, 8'hff, 16'hffff);
      issue(OP_SUBMIT, 32'd100, 8'h5a, 16'h0000);
      issue(OP_DISPATCH, 32'hffff_ffff, 8'hff, 16'hffff);
      issue(OP_DISPATCH, 32'd50, 8'h00, 16'h0000);
      // fill the remaining slots with equal ratios, then overflow the table
      for (int i = 1; i <= SLOTS - 1; i++)
         issue(OP_SUBMIT, 32'd1000, 8'(i), 16'd4);
      issue(OP_SUBMIT, 32'd1001, 8'haa, 16'd7);
      issue(OP_DISPATCH, 32'd1040, 8'h00, 16'h0000);
      issue(OP_DISPATCH, 32'd1040, 8'h00, 16'h0000);
      issue(OP_DISPATCH, 32'd0, 8'h00, 16'h0000);
      drain();

      // random: fill/empty episodes with random content, plus noise
      sched_time = $urandom;
      while (sent_count < RANDOM_TARGET) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            burst = $urandom_range(1, SLOTS + 2);
            repeat (burst) begin
               advance_time();
               issue(OP_SUBMIT, sched_time, 8'($urandom), pick_service());
            end
            repeat ($urandom_range(1, burst + 2)) begin
               advance_time();
               issue(OP_DISPATCH, sched_time, 8'($urandom), 16'($urandom));
            end
         end else if (mode < 8) begin
            repeat ($urandom_range(4, 20)) begin
               advance_time();
               issue(1'($urandom), sched_time, 8'($urandom), pick_service());
            end
         end else begin
            repeat ($urandom_range(2, 10))
               issue(1'($urandom), $urandom, 8'($urandom), 16'($urandom));
         end
         if (sent_count >= 400 && sent_count < 440) drain();
      end

      // wait for the last result, then allow for a stray one
      drain();
      repeat (3 * SLOTS + 10) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
